/* rtl/wtm_pkg.sv */
// package for the windowed throughput meter: window sizing, state types,
// control and status structs shared by the sequencer and the rate unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wtm_pkg;

	localparam int WINDOW_DEPTH = 4;
	localparam int HEAD_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

	localparam int DATA_W       = 64;
	localparam int SCALE_W      = 32;
	localparam int HALF_W       = 32;
	localparam int PROD_W       = DATA_W + SCALE_W;
	localparam int DIV_STEPS    = DATA_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);

	localparam logic [DATA_W-1:0]  U64_MAX   = {DATA_W{1'b1}};
	localparam logic [SCALE_W-1:0] TPS_RESET = 32'd1000000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_SUM,
		S_RATE_P,
		S_RATE_R,
		S_DONE
	} meter_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL_LO,
		U_MUL_HI,
		U_ADD,
		U_CHECK,
		U_DIV,
		U_DONE
	} rate_state_t;

	typedef struct packed {
		logic start;
	} rate_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic saturated;
	} rate_sts_t;

endpackage

`default_nettype wire

/* rtl/wtm_rate_unit.sv */
// shared rate unit: floor(bytes * scale / ticks) saturated to 64 bits,
// one 32x32 multiplier used twice, then a one-bit-per-cycle restoring divider
// depends on wtm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wtm_rate_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire wtm_pkg::rate_ctl_t        ctl,
	output wtm_pkg::rate_sts_t             sts,
	input  wire logic [wtm_pkg::DATA_W-1:0]  bytes,
	input  wire logic [wtm_pkg::SCALE_W-1:0] scale,
	input  wire logic [wtm_pkg::DATA_W-1:0]  ticks,
	output logic [wtm_pkg::DATA_W-1:0]       quotient
);
	import wtm_pkg::*;

	rate_state_t state_q, state_d;

	logic [HALF_W-1:0]  mul_a;
	logic [DATA_W-1:0]  mul_out;
	logic [DATA_W-1:0]  mul_lo_q;
	logic [DATA_W-1:0]  mul_hi_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DATA_W-1:0]  rem_q;
	logic [DATA_W-1:0]  quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               sat_q;
	logic [DATA_W-1:0]  prod_hi;
	logic [DATA_W:0]    rem_shift;
	logic               rem_ge;
	logic [DATA_W:0]    rem_sub;

	// one multiplier, low half of bytes first, then high half
	assign mul_a   = (state_q == U_MUL_LO) ? bytes[HALF_W-1:0] : bytes[DATA_W-1:HALF_W];
	assign mul_out = DATA_W'(mul_a) * DATA_W'(scale);

	assign prod_hi   = DATA_W'(prod_q[PROD_W-1:DATA_W]);
	assign rem_shift = {rem_q, quo_q[DATA_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, ticks};
	assign rem_sub   = rem_shift - {1'b0, ticks};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE:   if (ctl.start) state_d = U_MUL_LO;
			U_MUL_LO: state_d = U_MUL_HI;
			U_MUL_HI: state_d = U_ADD;
			U_ADD:    state_d = U_CHECK;
			U_CHECK:  state_d = (prod_hi >= ticks) ? U_DONE : U_DIV;
			U_DIV:    if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = U_DONE;
			U_DONE:   state_d = U_IDLE;
			default:  state_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			sat_q  <= 1'b0;
		end else begin
			case (state_q)
				U_CHECK: begin
					step_q <= '0;
					sat_q  <= prod_hi >= ticks;
				end
				U_DIV:   step_q <= step_q + STEP_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_MUL_LO: mul_lo_q <= mul_out;
			U_MUL_HI: mul_hi_q <= mul_out;
			U_ADD:    prod_q   <= {mul_hi_q, {HALF_W{1'b0}}} + PROD_W'(mul_lo_q);
			U_CHECK: begin
				if (prod_hi >= ticks) begin
					quo_q <= U64_MAX;
				end else begin
					rem_q <= prod_hi;
					quo_q <= prod_q[DATA_W-1:0];
				end
			end
			U_DIV: begin
				// remainder stays below ticks, so the low 64 bits hold it
				rem_q <= rem_ge ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], rem_ge};
			end
			default: ;
		endcase
	end

	assign quotient      = quo_q;
	assign sts.busy      = state_q != U_IDLE;
	assign sts.done      = state_q == U_DONE;
	assign sts.saturated = sat_q;

endmodule

`default_nettype wire

/* rtl/windowed_throughput_meter.sv */
// top level of the windowed throughput meter: sample registers, baseline,
// interval window, summing sequencer and output register
// depends on wtm_pkg and wtm_rate_unit
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                     direction  flow control
// -------   ---------------------------------------   ---------  ------------
// sample    in_valid, in_stall, 4 x 64-bit fields      in         valid/stall
// result    out_valid, out_stall, 5 x 64-bit + 1 bit   out        valid/stall
// config    cfg_valid, cfg_ready, cfg_data (32 bit)    in         valid/ready
//
// a sample passes through update and a summing pass over the filled window entries; unless the
// window is empty, two rate unit passes follow (start, multiply low and high halves, add, check,
// divide steps, done), and a pass skips the divide steps when the quotient saturates
// in_stall is high from the accepted transfer until the result enters the output register;
// a result held by out_stall blocks only the sample after the next one
// asynchronous reset clears baseline, fill and head and loads ticks_per_second = 1000000

module windowed_throughput_meter (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] processed_bytes,
	input  wire logic [63:0] total_bytes,
	input  wire logic [63:0] raw_bytes,
	input  wire logic [63:0] time_ticks,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      processed_clamped,
	output logic [63:0]      total_out,
	output logic [63:0]      raw_out,
	output logic [63:0]      processed_rate,
	output logic [63:0]      raw_rate,
	output logic             rate_valid,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	import wtm_pkg::*;

	meter_state_t state_q, state_d;

	// configuration
	logic [SCALE_W-1:0] tps_q;

	// accepted sample
	logic [DATA_W-1:0] proc_q;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] raw_q;
	logic [DATA_W-1:0] now_q;

	// baseline
	logic              base_valid_q;
	logic [DATA_W-1:0] last_time_q;
	logic [DATA_W-1:0] last_proc_q;
	logic [DATA_W-1:0] last_raw_q;

	// interval window, written at the head, read at the summing index
	logic [DATA_W-1:0] win_proc_q [WINDOW_DEPTH];
	logic [DATA_W-1:0] win_raw_q  [WINDOW_DEPTH];
	logic [DATA_W-1:0] win_tick_q [WINDOW_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [HEAD_W-1:0] head_q;

	// summing pass
	logic [FILL_W-1:0] idx_q;
	logic [DATA_W-1:0] sum_p_q;
	logic [DATA_W-1:0] sum_r_q;
	logic [DATA_W-1:0] sum_t_q;
	logic [DATA_W:0]   add_p;
	logic [DATA_W:0]   add_r;
	logic [DATA_W:0]   add_t;
	logic              sum_more;

	// result being built
	logic [DATA_W-1:0] clamp_q;
	logic [DATA_W-1:0] rate_p_q;
	logic [DATA_W-1:0] rate_r_q;
	logic              have_rate_q;
	logic              launch_q;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_clamp_q;
	logic [DATA_W-1:0] out_total_q;
	logic [DATA_W-1:0] out_raw_q;
	logic [DATA_W-1:0] out_rate_p_q;
	logic [DATA_W-1:0] out_rate_r_q;
	logic              out_rate_valid_q;

	logic              in_take;
	logic              out_take;
	logic              out_load;
	logic              push;

	rate_ctl_t         unit_ctl;
	rate_sts_t         unit_sts;
	logic [DATA_W-1:0] unit_bytes;
	logic [DATA_W-1:0] unit_q;

	assign in_stall  = state_q != S_IDLE;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	// the result moves on once the output register is empty or being drained
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// an interval is pushed only after a baseline and for a later timestamp
	assign push = base_valid_q && (now_q > last_time_q);

	assign sum_more = idx_q < fill_q;
	assign add_p    = {1'b0, sum_p_q} + {1'b0, win_proc_q[idx_q[HEAD_W-1:0]]};
	assign add_r    = {1'b0, sum_r_q} + {1'b0, win_raw_q[idx_q[HEAD_W-1:0]]};
	assign add_t    = {1'b0, sum_t_q} + {1'b0, win_tick_q[idx_q[HEAD_W-1:0]]};

	assign unit_ctl.start = launch_q;
	assign unit_bytes     = (state_q == S_RATE_R) ? sum_r_q : sum_p_q;

	wtm_rate_unit u_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (unit_ctl),
		.sts      (unit_sts),
		.bytes    (unit_bytes),
		.scale    (tps_q),
		.ticks    (sum_t_q),
		.quotient (unit_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_take) state_d = S_UPDATE;
			S_UPDATE: state_d = S_SUM;
			S_SUM: begin
				if (!sum_more) begin
					state_d = (sum_t_q != '0) ? S_RATE_P : S_DONE;
				end
			end
			S_RATE_P: if (unit_sts.done) state_d = S_RATE_R;
			S_RATE_R: if (unit_sts.done) state_d = S_DONE;
			S_DONE:   if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tps_q <= cfg_data;
		end
	end

	// control state: baseline flag, window pointers, launches, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q <= 1'b0;
			fill_q       <= '0;
			head_q       <= '0;
			idx_q        <= '0;
			launch_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			case (state_q)
				S_UPDATE: begin
					idx_q <= '0;
					if (!base_valid_q) begin
						// first sample only sets the baseline
						base_valid_q <= 1'b1;
						fill_q       <= '0;
						head_q       <= '0;
					end else if (push) begin
						head_q <= (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0
						        : head_q + HEAD_W'(1);
						if (fill_q < FILL_W'(WINDOW_DEPTH)) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				S_SUM: begin
					if (sum_more) begin
						idx_q <= idx_q + FILL_W'(1);
					end else if (sum_t_q != '0) begin
						launch_q <= 1'b1;
					end
				end
				S_RATE_P: if (unit_sts.done) launch_q <= 1'b1;
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			proc_q  <= processed_bytes;
			total_q <= total_bytes;
			raw_q   <= raw_bytes;
			now_q   <= time_ticks;
		end

		case (state_q)
			S_UPDATE: begin
				if (push) begin
					// byte deltas clamp to zero when a counter went back
					win_proc_q[head_q] <= (proc_q >= last_proc_q) ? proc_q - last_proc_q : '0;
					win_raw_q[head_q]  <= (raw_q >= last_raw_q) ? raw_q - last_raw_q : '0;
					win_tick_q[head_q] <= now_q - last_time_q;
				end
				last_time_q <= now_q;
				last_proc_q <= proc_q;
				last_raw_q  <= raw_q;
				clamp_q     <= (proc_q < total_q) ? proc_q : total_q;
				sum_p_q     <= '0;
				sum_r_q     <= '0;
				sum_t_q     <= '0;
			end
			S_SUM: begin
				if (sum_more) begin
					// saturating sums
					sum_p_q <= add_p[DATA_W] ? U64_MAX : add_p[DATA_W-1:0];
					sum_r_q <= add_r[DATA_W] ? U64_MAX : add_r[DATA_W-1:0];
					sum_t_q <= add_t[DATA_W] ? U64_MAX : add_t[DATA_W-1:0];
				end else begin
					rate_p_q    <= '0;
					rate_r_q    <= '0;
					have_rate_q <= sum_t_q != '0;
				end
			end
			S_RATE_P: if (unit_sts.done) rate_p_q <= unit_q;
			S_RATE_R: if (unit_sts.done) rate_r_q <= unit_q;
			default: ;
		endcase

		if (out_load) begin
			out_clamp_q      <= clamp_q;
			out_total_q      <= total_q;
			out_raw_q        <= raw_q;
			out_rate_p_q     <= rate_p_q;
			out_rate_r_q     <= rate_r_q;
			out_rate_valid_q <= have_rate_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign processed_clamped = out_clamp_q;
	assign total_out         = out_total_q;
	assign raw_out           = out_raw_q;
	assign processed_rate    = out_rate_p_q;
	assign raw_rate          = out_rate_r_q;
	assign rate_valid        = out_rate_valid_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("window fill beyond depth");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		unit_ctl.start |-> !unit_sts.busy)
		else $error("rate unit started while busy");

	a_done_in_rate: assert property (@(posedge clk) disable iff (!arst_n)
		unit_sts.done |-> (state_q == S_RATE_P || state_q == S_RATE_R))
		else $error("rate unit finished outside a rate pass");

	a_no_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rate_valid) |-> (processed_rate == '0 && raw_rate == '0))
		else $error("rate reported without window time");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (processed_clamped <= total_out))
		else $error("processed count above total");
`endif

endmodule

`default_nettype wire

/* sim/tb_windowed_throughput_meter.sv */
// testbench for windowed_throughput_meter: directed and random samples checked
// field by field against an in-bench predictor of the interval window and rates
// depends on wtm_pkg and the windowed_throughput_meter rtl
`timescale 1ns / 1ps

module tb_windowed_throughput_meter;

	import wtm_pkg::*;

	// clock half period, reset length, idle watchdog, receiver holdoff, settle time and closing tail
	localparam int  CLK_HALF      = 2;
	localparam int  RESET_CYCLES  = 7;
	localparam int  WATCHDOG_MAX  = 4000;
	localparam int  HOLDOFF_LEN   = 600;
	localparam int  SETTLE_CYCLES = 8;
	localparam int  TAIL_CYCLES   = 150;

	// one result transfer, in port order
	typedef struct packed {
		logic [63:0] processed_clamped;
		logic [63:0] total_out;
		logic [63:0] raw_out;
		logic [63:0] processed_rate;
		logic [63:0] raw_rate;
		logic        rate_valid;
	} meter_result_t;

	logic        clk;
	logic        arst_n;

	logic        in_valid;
	logic        in_stall;
	logic [63:0] processed_bytes;
	logic [63:0] total_bytes;
	logic [63:0] raw_bytes;
	logic [63:0] time_ticks;

	logic        out_valid;
	logic        out_stall;
	logic [63:0] processed_clamped;
	logic [63:0] total_out;
	logic [63:0] raw_out;
	logic [63:0] processed_rate;
	logic [63:0] raw_rate;
	logic        rate_valid;

	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	windowed_throughput_meter dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.processed_bytes   (processed_bytes),
		.total_bytes       (total_bytes),
		.raw_bytes         (raw_bytes),
		.time_ticks        (time_ticks),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.processed_clamped (processed_clamped),
		.total_out         (total_out),
		.raw_out           (raw_out),
		.processed_rate    (processed_rate),
		.raw_rate          (raw_rate),
		.rate_valid        (rate_valid),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	// ------------------------------------------------------------------
	// predictor state: baseline, interval window and rate scale
	// ------------------------------------------------------------------
	logic [31:0]   scale_tps     = TPS_RESET;
	logic          have_baseline = 1'b0;
	logic [63:0]   prev_time     = '0;
	logic [63:0]   prev_proc     = '0;
	logic [63:0]   prev_raw      = '0;
	logic [63:0]   win_proc  [WINDOW_DEPTH];
	logic [63:0]   win_raw   [WINDOW_DEPTH];
	logic [63:0]   win_ticks [WINDOW_DEPTH];
	int            win_fill      = 0;
	int            win_head      = 0;

	meter_result_t pending_results[$];
	int            mismatches    = 0;
	int            quiet_cycles  = 0;

	// stimulus controls set by the tests, read by the sender and the receiver process
	bit            tx_idle_en    = 1'b1;
	bit            rx_idle_en    = 1'b1;
	bit            long_hold_req = 1'b0;

	// cursors of the sample generator: cumulative counters and clock
	logic [63:0]   gen_proc      = '0;
	logic [63:0]   gen_raw       = '0;
	logic [63:0]   gen_time      = '0;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? U64_MAX : s[63:0];
	endfunction

	// floor(bytes * scale / ticks) with saturation, ticks nonzero
	function automatic logic [63:0] bytes_per_second(input logic [63:0] bytes,
			input logic [31:0] scale, input logic [63:0] ticks);
		logic [127:0] q;
		q = ({64'd0, bytes} * {96'd0, scale}) / {64'd0, ticks};
		return (q[127:64] != '0) ? U64_MAX : q[63:0];
	endfunction

	// advance the window for one accepted sample and queue its result
	function automatic void predict_sample(input logic [63:0] p, input logic [63:0] tot,
			input logic [63:0] r, input logic [63:0] ts);
		logic [63:0]   sum_p;
		logic [63:0]   sum_r;
		logic [63:0]   sum_t;
		meter_result_t want;
		sum_p = '0;
		sum_r = '0;
		sum_t = '0;
		if (!have_baseline) begin
			// first sample only sets the baseline
			have_baseline = 1'b1;
			win_fill = 0;
			win_head = 0;
		end else if (ts > prev_time) begin
			// counters that went back contribute nothing
			win_proc[win_head]  = (p >= prev_proc) ? p - prev_proc : 64'd0;
			win_raw[win_head]   = (r >= prev_raw) ? r - prev_raw : 64'd0;
			win_ticks[win_head] = ts - prev_time;
			win_head = (win_head + 1) % WINDOW_DEPTH;
			if (win_fill < WINDOW_DEPTH)
				win_fill++;
		end
		// baseline follows every sample, stale timestamps included
		prev_time = ts;
		prev_proc = p;
		prev_raw  = r;
		for (int k = 0; k < win_fill; k++) begin
			sum_p = sat_add64(sum_p, win_proc[k]);
			sum_r = sat_add64(sum_r, win_raw[k]);
			sum_t = sat_add64(sum_t, win_ticks[k]);
		end
		want.processed_clamped = (p < tot) ? p : tot;
		want.total_out         = tot;
		want.raw_out           = r;
		if (sum_t != '0) begin
			want.processed_rate = bytes_per_second(sum_p, scale_tps, sum_t);
			want.raw_rate       = bytes_per_second(sum_r, scale_tps, sum_t);
			want.rate_valid     = 1'b1;
		end else begin
			want.processed_rate = '0;
			want.raw_rate       = '0;
			want.rate_valid     = 1'b0;
		end
		pending_results.insert(pending_results.size(), want);
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial begin : clock_gen
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// monitor: every value read here is the one the block sees at the edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		meter_result_t want;
		logic          moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				scale_tps = cfg_data;
				moved = 1'b1;
			end
			// results first, so the oldest expectation is matched
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					$error("result transfer with no expected result pending");
					mismatches++;
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					check_field("processed_clamped", want.processed_clamped,
						processed_clamped);
					check_field("total_out", want.total_out, total_out);
					check_field("raw_out", want.raw_out, raw_out);
					check_field("processed_rate", want.processed_rate, processed_rate);
					check_field("raw_rate", want.raw_rate, raw_rate);
					check_field("rate_valid", {63'd0, want.rate_valid},
						{63'd0, rate_valid});
				end
			end
			if (in_valid && !in_stall) begin
				predict_sample(processed_bytes, total_bytes, raw_bytes, time_ticks);
				moved = 1'b1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	// watchdog: too long with no transfer on any channel
	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_MAX)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: random stall bursts, plus one long holdoff on request
	// ------------------------------------------------------------------
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				// hold long enough for the block to back up into its input
				out_stall <= 1'b1;
				repeat (HOLDOFF_LEN) @(negedge clk);
				long_hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// sender helpers: entered and left at a falling edge
	// ------------------------------------------------------------------
	task automatic send_sample(input logic [63:0] p, input logic [63:0] tot,
			input logic [63:0] r, input logic [63:0] ts);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid        <= 1'b1;
		processed_bytes <= p;
		total_bytes     <= tot;
		raw_bytes       <= r;
		time_ticks      <= ts;
		// valid stays up after the transfer; the next call or a pause moves it
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// pause the sender until every expected result has been seen
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_tps(input logic [31:0] value);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// byte increment: small, 32-bit or wide
	function automatic logic [63:0] rand_span();
		case ($urandom_range(0, 2))
			0:       return 64'($urandom_range(0, 4096));
			1:       return 64'($urandom);
			default: return rand64() >> $urandom_range(0, 63);
		endcase
	endfunction

	function automatic logic [63:0] rand_ticks();
		if ($urandom_range(0, 4) != 0)
			return 64'($urandom_range(1, 2000));
		return (rand64() >> $urandom_range(8, 63)) | 64'd1;
	endfunction

	// mostly well-formed progress; some stale clocks, rollbacks and noise
	task automatic send_random_sample();
		logic [63:0] tot;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			gen_proc += rand_span();
			gen_raw  += rand_span();
			gen_time += rand_ticks();
		end else if (pick < 80) begin
			// timestamp equal or earlier than the baseline
			gen_proc += rand_span();
			gen_raw  += rand_span();
			gen_time -= 64'($urandom_range(0, 100));
		end else if (pick < 90) begin
			// counters going back
			gen_proc -= rand_span();
			gen_raw  -= rand_span();
			gen_time += rand_ticks();
		end else begin
			gen_proc = rand64();
			gen_raw  = rand64();
			gen_time = rand64();
		end
		case ($urandom_range(0, 3))
			0:       tot = rand64();
			1:       tot = gen_proc;
			2:       tot = gen_proc + 64'($urandom_range(0, 5000));
			default: tot = gen_proc - 64'($urandom_range(0, 5000));
		endcase
		send_sample(gen_proc, tot, gen_raw, gen_time);
	endtask

	task automatic run_traffic(input int count);
		repeat (count) send_random_sample();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// baseline on the first sample, then stale and earlier timestamps
	task automatic test_baseline_and_stale_time();
		send_sample(64'd0, 64'd0, 64'd0, 64'd0);
		send_sample(64'd100, 64'd50, 64'd200, 64'd0);
		send_sample(64'd300, 64'd1000, 64'd500, 64'd10);
		send_sample(64'd400, 64'd1000, 64'd600, 64'd10);
		send_sample(64'd500, 64'd1000, 64'd700, 64'd5);
		send_sample(64'd900, 64'd1000, 64'd900, 64'd25);
	endtask

	// counters that step back, then a jump to all ones
	task automatic test_counter_rollback();
		send_sample(64'd100, 64'd1000, 64'd100, 64'd30);
		send_sample(U64_MAX, U64_MAX, U64_MAX, 64'd31);
	endtask

	// more intervals than the window holds, oldest gets overwritten
	task automatic test_window_wrap();
		for (int i = 0; i < WINDOW_DEPTH + 1; i++)
			send_sample(64'(i * 1000), 64'h8000_0000_0000_0000, 64'(i * 3000),
				64'(40 + i * 7));
	endtask

	// saturating window sums, then a rate too large for 64 bits
	task automatic test_sum_and_rate_saturation();
		send_sample(64'd0, 64'd0, 64'd0, 64'd0);
		send_sample(U64_MAX, 64'd1, U64_MAX, U64_MAX);
		send_sample(64'd0, 64'd0, 64'd0, 64'd0);
		send_sample(U64_MAX, 64'd1, U64_MAX, U64_MAX);
		send_sample(64'd0, U64_MAX, 64'd0, 64'd0);
		for (int i = 1; i <= WINDOW_DEPTH; i++)
			send_sample((i == WINDOW_DEPTH) ? U64_MAX : 64'(i) << 62, U64_MAX,
				64'(i) << 61, 64'(i));
	endtask

	// receiver holds off while the sender keeps offering, then a full drain
	task automatic test_receiver_holdoff();
		long_hold_req = 1'b1;
		run_traffic(8);
		wait_for_results();
	endtask

	// traffic under several rate scales, extremes and zero included
	task automatic test_scale_settings();
		write_tps(32'd1);
		run_traffic(220);
		write_tps(32'hFFFF_FFFF);
		run_traffic(220);
		write_tps(32'd0);
		run_traffic(150);
		write_tps($urandom);
		run_traffic(250);
		write_tps(TPS_RESET);
	endtask

	// last stretch at full rate on both sides
	task automatic test_full_rate_finish();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_traffic(380);
		wait_for_results();
	endtask

	initial begin : main
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		processed_bytes = '0;
		total_bytes     = '0;
		raw_bytes       = '0;
		time_ticks      = '0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_baseline_and_stale_time();
		test_counter_rollback();
		test_window_wrap();
		test_sum_and_rate_saturation();
		test_receiver_holdoff();
		test_scale_settings();
		test_full_rate_finish();

		// catch any stray result after the last expected one
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* windowed_throughput_meter.f */
rtl/wtm_pkg.sv
rtl/wtm_rate_unit.sv
rtl/windowed_throughput_meter.sv
sim/tb_windowed_throughput_meter.sv
